### sv/psj_pkg.sv
// psj_pkg: constants, config codes and small helper functions for the pixel scatter jitter core
// no dependencies; used by psj_div, pixel_scatter_jitter_core and the testbench

package psj_pkg;

	// geometry limits
	localparam int MAX_WIDTH   = 1024;
	localparam int STORE_DEPTH = 8192;              // power of two, at least 6*MAX_WIDTH+7
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// field and counter widths
	localparam int PIX_W   = 32;
	localparam int JIT_W   = 9;
	localparam int WIDTH_W = 11;                    // frame_width register
	localparam int HEIGHT_W = 16;                   // frame_height register
	localparam int POS_W   = 26;                    // frame positions, up to width*height
	localparam int LAG_W   = 12;                    // 3*width+3 and pending count
	localparam int OFF_W   = WIDTH_W + 4;           // signed neighbour offset
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MAX_LAG = 3 * MAX_WIDTH + 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;

	// item operations
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// register reset values
	localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
	localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 16'd480;
	localparam logic [POS_W-1:0]    RST_FSIZE  = 26'd307200;
	localparam logic [LAG_W-1:0]    RST_LAG    = 12'd1923;

	// width clamped to 1..MAX_WIDTH
	function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
		logic [WIDTH_W-1:0] r;
		r = v;
		if (v == '0)
			r = WIDTH_W'(1);
		else if (v > WIDTH_W'(MAX_WIDTH))
			r = WIDTH_W'(MAX_WIDTH);
		return r;
	endfunction

	// height raised to at least eight rows
	function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] v);
		return (v < HEIGHT_W'(8)) ? HEIGHT_W'(8) : v;
	endfunction

	// 3-bit jitter code to a step of -3..3 (v-4, negatives raised by one)
	function automatic logic signed [2:0] jit_step(input logic [2:0] v);
		return (v < 3'd4) ? 3'(v - 3'd3) : 3'(v - 3'd4);
	endfunction

endpackage

### sv/psj_ram.sv
// psj_ram: generic simple dual-port RAM, one write and one registered read per cycle
// no dependencies

module psj_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read port, read-first on collision
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### sv/psj_div.sv
// psj_div: restoring divider, one quotient bit per cycle, splits a position into row and column
// depends on psj_pkg for widths

module psj_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [psj_pkg::POS_W-1:0]    dividend,
	input  logic [psj_pkg::WIDTH_W-1:0]  divisor,
	output logic                         done,
	output logic [psj_pkg::POS_W-1:0]    quotient,
	output logic [psj_pkg::WIDTH_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(psj_pkg::POS_W);

	logic                         run_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [psj_pkg::POS_W-1:0]    quo_q;
	logic [psj_pkg::WIDTH_W-1:0]  rem_q;
	logic [psj_pkg::WIDTH_W:0]    trial;
	logic [psj_pkg::WIDTH_W:0]    diff;
	logic                         ge;
	logic                         last_step;

	// one trial subtraction per cycle
	always_comb begin
		trial     = {rem_q, quo_q[psj_pkg::POS_W-1]};
		diff      = trial - {1'b0, divisor};
		ge        = trial >= {1'b0, divisor};
		last_step = cnt_q == CNT_W'(psj_pkg::POS_W - 1);
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last_step && !start;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_step)
					run_q <= 1'b0;
			end
		end
	end

	// dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[psj_pkg::POS_W-2:0], ge};
			rem_q <= ge ? diff[psj_pkg::WIDTH_W-1:0] : trial[psj_pkg::WIDTH_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### sv/pixel_scatter_jitter_core.sv
// pixel_scatter_jitter_core: streaming 7x7 random-neighbour pixel scatter over a pixel store
// depends on psj_pkg, psj_ram (pixel store) and psj_div (row/column recompute)
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | op, pixel_in, jitter, frame_bypass
//  out     | out_valid / out_ready| pixel_out, last_of_frame
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One item per cycle while in_ready is high. A taken item's result goes through
// the registered store read stage into a three-entry output buffer.
// Each configuration write recomputes frame size and the output row/column with
// a bit-serial divider; input is held off until the recompute has finished.
// Output stalls back up through the buffer; input stalls when three results are
// buffered or in flight. The pixel store needs no clearing after reset.

module pixel_scatter_jitter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// input items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [psj_pkg::PIX_W-1:0]      pixel_in,
	input  logic [psj_pkg::JIT_W-1:0]      jitter,
	input  logic                           frame_bypass,
	// result items
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [psj_pkg::PIX_W-1:0]      pixel_out,
	output logic                           last_of_frame,
	// configuration
	input  logic                           cfg_we,
	input  logic [psj_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psj_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = psj_pkg::STORE_AW;
	localparam int FIFO_DEPTH = 3;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SIZE = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	// configuration and derived geometry
	logic                            enabled_q;
	logic [psj_pkg::WIDTH_W-1:0]     eff_w_q;
	logic [psj_pkg::HEIGHT_W-1:0]    eff_h_q;
	logic [psj_pkg::POS_W-1:0]       fsize_q;
	logic [psj_pkg::LAG_W-1:0]       lag_q;
	logic [1:0]                      state_q;
	logic [1:0]                      state_d;

	// stream state
	logic [AW-1:0]                   wp_q;
	logic [psj_pkg::POS_W-1:0]       in_pos_q;
	logic [psj_pkg::POS_W-1:0]       out_pos_q;
	logic [psj_pkg::POS_W-1:0]       out_row_q;
	logic [psj_pkg::WIDTH_W-1:0]     out_col_q;
	logic [psj_pkg::LAG_W-1:0]       pend_q;
	logic                            byp_in_q;
	logic                            byp_out_q;

	// read stage and output buffer
	logic                            valid_s1;
	logic                            last_s1;
	logic                            fwd_s1;
	logic [psj_pkg::PIX_W-1:0]       fwd_pix_s1;
	logic [1:0]                      fifo_cnt_q;
	logic [1:0]                      fifo_head_q;
	logic [1:0]                      fifo_tail_q;
	logic [psj_pkg::PIX_W-1:0]       fifo_pix_q  [FIFO_DEPTH];
	logic                            fifo_last_q [FIFO_DEPTH];

	// combinational
	logic                            accept;
	logic                            is_pixel;
	logic                            gen;
	logic                            take;
	logic [psj_pkg::LAG_W:0]         pend_inc;
	logic                            byp_in_nx;
	logic                            byp_out_nx;
	logic                            copy;
	logic [AW-1:0]                   slot;
	logic signed [psj_pkg::OFF_W-1:0] offset;
	logic [AW-1:0]                   nb_slot;
	logic [AW-1:0]                   raddr;
	logic                            store_we;
	logic [psj_pkg::PIX_W-1:0]       ram_rdata;
	logic                            out_last;
	logic [psj_pkg::POS_W:0]         out_pos_inc;
	logic [psj_pkg::POS_W:0]         in_pos_inc;
	logic [psj_pkg::WIDTH_W:0]       col_inc;
	logic [psj_pkg::POS_W:0]         fsize_prod;
	logic [psj_pkg::LAG_W-1:0]       lag_calc;
	logic                            push;
	logic                            pop;
	logic                            div_done;
	logic [psj_pkg::POS_W-1:0]       div_quo;
	logic [psj_pkg::WIDTH_W-1:0]     div_rem;
	logic [2:0]                      in_flight;

	function automatic logic [1:0] fifo_next(input logic [1:0] p);
		return (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	// handshakes
	assign in_flight = {1'b0, fifo_cnt_q} + {2'b0, valid_s1};
	assign in_ready  = (state_q == ST_IDLE) && (in_flight < 3'(FIFO_DEPTH));
	assign accept    = in_valid && in_ready;
	assign is_pixel  = op == psj_pkg::OP_PIXEL;
	assign out_valid = fifo_cnt_q != 2'd0;
	assign pop       = out_valid && out_ready;
	assign push      = valid_s1;

	// output pacing: a pixel emits once more than lag pixels are pending
	assign pend_inc = {1'b0, pend_q} + (psj_pkg::LAG_W + 1)'(1);
	assign gen      = is_pixel ? (pend_inc > {1'b0, lag_q}) : (pend_q != '0);
	assign take     = accept && gen;

	// bypass latches as updated by this item
	assign byp_in_nx  = (is_pixel && in_pos_q == '0) ? frame_bypass : byp_in_q;
	assign byp_out_nx = (out_pos_q == '0) ? byp_in_nx : byp_out_q;

	// copy or scatter decision for the emitted pixel
	always_comb begin
		copy = !enabled_q || byp_out_nx || (out_row_q < psj_pkg::POS_W'(4)) ||
		       (out_row_q >= psj_pkg::POS_W'(eff_h_q - psj_pkg::HEIGHT_W'(4)));
	end

	// store addresses: emitted slot and its jittered neighbour
	always_comb begin
		slot    = wp_q - AW'(pend_q);
		offset  = psj_pkg::OFF_W'($signed({1'b0, eff_w_q})) *
		          psj_pkg::OFF_W'(psj_pkg::jit_step(jitter[5:3])) +
		          psj_pkg::OFF_W'(psj_pkg::jit_step(jitter[2:0]));
		nb_slot = slot + AW'(offset);
		raddr   = copy ? slot : nb_slot;
	end

	assign store_we = accept && is_pixel;

	// position advance
	assign out_pos_inc = {1'b0, out_pos_q} + (psj_pkg::POS_W + 1)'(1);
	assign out_last    = out_pos_inc >= {1'b0, fsize_q};
	assign in_pos_inc  = {1'b0, in_pos_q} + (psj_pkg::POS_W + 1)'(1);
	assign col_inc     = {1'b0, out_col_q} + (psj_pkg::WIDTH_W + 1)'(1);

	// geometry from the clamped registers
	assign fsize_prod = eff_w_q * eff_h_q;
	assign lag_calc   = ({1'b0, eff_w_q} << 1) + {1'b0, eff_w_q} + psj_pkg::LAG_W'(3);

	// recompute sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: state_d = ST_IDLE;
			ST_SIZE: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we)
			state_d = ST_SIZE;
	end

	// configuration registers and geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			enabled_q <= 1'b1;
			eff_w_q   <= psj_pkg::RST_WIDTH;
			eff_h_q   <= psj_pkg::RST_HEIGHT;
			fsize_q   <= psj_pkg::RST_FSIZE;
			lag_q     <= psj_pkg::RST_LAG;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					psj_pkg::CFG_ENABLED: enabled_q <= cfg_data[0];
					psj_pkg::CFG_WIDTH:
						eff_w_q <= psj_pkg::eff_width(cfg_data[psj_pkg::WIDTH_W-1:0]);
					psj_pkg::CFG_HEIGHT: eff_h_q <= psj_pkg::eff_height(cfg_data);
					default: ;
				endcase
			end
			if (state_q == ST_SIZE) begin
				fsize_q <= fsize_prod[psj_pkg::POS_W-1:0];
				lag_q   <= lag_calc;
			end
		end
	end

	// stream counters and bypass latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			in_pos_q  <= '0;
			out_pos_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pend_q    <= '0;
			byp_in_q  <= 1'b0;
			byp_out_q <= 1'b0;
		end else begin
			if (store_we) begin
				wp_q     <= wp_q + AW'(1);
				byp_in_q <= byp_in_nx;
				in_pos_q <= (in_pos_inc >= {1'b0, fsize_q}) ? '0 :
				            in_pos_inc[psj_pkg::POS_W-1:0];
			end
			if (accept) begin
				if (is_pixel && !gen)
					pend_q <= pend_inc[psj_pkg::LAG_W-1:0];
				else if (!is_pixel && gen)
					pend_q <= pend_q - psj_pkg::LAG_W'(1);
			end
			if (take) begin
				byp_out_q <= byp_out_nx;
				if (out_last) begin
					out_pos_q <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else begin
					out_pos_q <= out_pos_inc[psj_pkg::POS_W-1:0];
					if (col_inc == {1'b0, eff_w_q}) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + psj_pkg::POS_W'(1);
					end else begin
						out_col_q <= col_inc[psj_pkg::WIDTH_W-1:0];
					end
				end
			end
			// after a configuration write: row and column from the divider
			if (state_q == ST_DIV && div_done) begin
				out_row_q <= div_quo;
				out_col_q <= div_rem;
			end
		end
	end

	// pixel store
	psj_ram #(
		.WIDTH (psj_pkg::PIX_W),
		.DEPTH (psj_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (wp_q),
		.wdata (pixel_in),
		.re    (take),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// row/column divider
	psj_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_SIZE),
		.dividend  (out_pos_q),
		.divisor   (eff_w_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= take;
	end

	// read stage payload, forwarding the pixel written in the same cycle
	always_ff @(posedge clk) begin
		if (take) begin
			last_s1    <= out_last;
			fwd_s1     <= store_we && (raddr == wp_q);
			fwd_pix_s1 <= pixel_in;
		end
	end

	// output buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_cnt_q  <= '0;
			fifo_head_q <= '0;
			fifo_tail_q <= '0;
		end else begin
			if (push)
				fifo_tail_q <= fifo_next(fifo_tail_q);
			if (pop)
				fifo_head_q <= fifo_next(fifo_head_q);
			if (push && !pop)
				fifo_cnt_q <= fifo_cnt_q + 2'd1;
			else if (pop && !push)
				fifo_cnt_q <= fifo_cnt_q - 2'd1;
		end
	end

	// output buffer entries
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_pix_q[fifo_tail_q]  <= fwd_s1 ? fwd_pix_s1 : ram_rdata;
			fifo_last_q[fifo_tail_q] <= last_s1;
		end
	end

	assign pixel_out     = fifo_pix_q[fifo_head_q];
	assign last_of_frame = fifo_last_q[fifo_head_q];

`ifndef SYNTHESIS
	// a result in the read stage always finds room in the output buffer
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (fifo_cnt_q < 2'(FIFO_DEPTH)))
		else $error("output buffer overflow");

	// when taking items the column lies inside the current width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (out_col_q < eff_w_q))
		else $error("output column out of range");

	// pending pixels never exceed the largest lag plus one
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= psj_pkg::LAG_W'(psj_pkg::MAX_LAG + 1))
		else $error("pending count out of range");

	// a taken result is in the read stage at the next edge
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("result lost before read stage");
`endif

endmodule

### sim/testbench.sv
// testbench for pixel_scatter_jitter_core: directed table with typed results, then random phases over
// geometry, enable and bypass settings; untyped outputs checked against a cycle-free scatter predictor
// depends on psj_pkg and the core RTL

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import psj_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;   // index past the register list
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS = 24;

	typedef struct packed {
		logic              op;
		logic [PIX_W-1:0]  pix;
		logic [JIT_W-1:0]  jit;
		logic              byp;
	} pixel_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic              last;
	} pixel_result_t;

	// one directed row; typed rows carry the result read straight off the geometry
	typedef struct packed {
		logic              op;
		logic [PIX_W-1:0]  pix;
		logic [JIT_W-1:0]  jit;
		logic              byp;
		bit                typed;
		bit                has_res;
		logic [PIX_W-1:0]  res_pix;
		logic              res_last;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  op;
	logic [PIX_W-1:0]      pixel_in;
	logic [JIT_W-1:0]      jitter;
	logic                  frame_bypass;
	logic                  out_valid;
	logic                  out_ready;
	logic [PIX_W-1:0]      pixel_out;
	logic                  last_of_frame;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirror of the block state and registers
	logic [PIX_W-1:0]      mirror_store [STORE_DEPTH];
	bit                    mirror_written [STORE_DEPTH];
	logic [STORE_AW-1:0]   mirror_wptr = '0;
	logic [POS_W-1:0]      mirror_in_pos = '0;
	logic [POS_W-1:0]      mirror_out_pos = '0;
	logic [LAG_W-1:0]      mirror_pend = '0;
	logic                  mirror_byp_in = 1'b0;
	logic                  mirror_byp_out = 1'b0;
	logic                  mirror_en = 1'b1;
	logic [WIDTH_W-1:0]    mirror_w = RST_WIDTH;
	logic [HEIGHT_W-1:0]   mirror_h = RST_HEIGHT;

	pixel_result_t         expected_pixels [$];
	dir_row_t              dir_tab [DIR_ROWS];
	int                    mismatch_count = 0;
	int                    idle_pct = 0;
	int                    stall_pct = 0;
	int unsigned           cycle_count = 0;

	pixel_scatter_jitter_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.pixel_in      (pixel_in),
		.jitter        (jitter),
		.frame_bypass  (frame_bypass),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_out     (pixel_out),
		.last_of_frame (last_of_frame),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// width clamped to 1..MAX_WIDTH
	function automatic int mirror_width();
		if (mirror_w == '0)
			return 1;
		if (mirror_w > WIDTH_W'(MAX_WIDTH))
			return MAX_WIDTH;
		return int'(mirror_w);
	endfunction

	// height raised to eight rows
	function automatic int mirror_height();
		return (mirror_h < HEIGHT_W'(8)) ? 8 : int'(mirror_h);
	endfunction

	// 3-bit jitter code to -3..3
	function automatic int neighbour_step(input logic [2:0] v);
		int d;
		d = int'(v) - 4;
		if (d < 0)
			d = d + 1;
		return d;
	endfunction

	// store slot the item's output would read, from the state before the item; 0 if no output
	function automatic bit locate_source(input pixel_item_t it, output logic [STORE_AW-1:0] src,
			output bit copy_pix);
		int w, h, row, nb;
		logic byp_i, byp_o;
		logic [STORE_AW-1:0] slot;
		w = mirror_width();
		h = mirror_height();
		src = '0;
		copy_pix = 1'b1;
		if (it.op == OP_PIXEL) begin
			if (int'(mirror_pend) + 1 <= 3 * w + 3)
				return 1'b0;
		end else if (mirror_pend == '0) begin
			return 1'b0;
		end
		byp_i = (it.op == OP_PIXEL && mirror_in_pos == '0) ? it.byp : mirror_byp_in;
		byp_o = (mirror_out_pos == '0) ? byp_i : mirror_byp_out;
		slot = mirror_wptr - STORE_AW'(mirror_pend);
		row = int'(mirror_out_pos) / w;
		copy_pix = !mirror_en || byp_o || row < 4 || row >= h - 4;
		if (copy_pix) begin
			src = slot;
		end else begin
			nb = int'(slot) + w * neighbour_step(it.jit[5:3]) + neighbour_step(it.jit[2:0]);
			src = nb[STORE_AW-1:0];
		end
		return 1'b1;
	endfunction

	// advance the mirror by one accepted item and produce its output pixel, if any
	function automatic bit predict_scatter(input pixel_item_t it, output pixel_result_t res);
		logic [STORE_AW-1:0] src;
		bit copy_pix;
		bit emits;
		int fsize;
		fsize = mirror_width() * mirror_height();
		res = '0;
		emits = locate_source(it, src, copy_pix);
		if (it.op == OP_PIXEL) begin
			if (mirror_in_pos == '0)
				mirror_byp_in = it.byp;
			mirror_store[mirror_wptr] = it.pix;
			mirror_written[mirror_wptr] = 1'b1;
			mirror_wptr = mirror_wptr + 1'b1;
			mirror_in_pos = mirror_in_pos + 1'b1;
			if (int'(mirror_in_pos) >= fsize)
				mirror_in_pos = '0;
			mirror_pend = mirror_pend + 1'b1;
		end
		if (!emits)
			return 1'b0;
		if (mirror_out_pos == '0)
			mirror_byp_out = mirror_byp_in;
		res.pix = mirror_written[src] ? mirror_store[src] : '0;
		res.last = (int'(mirror_out_pos) + 1 >= fsize);
		mirror_out_pos = mirror_out_pos + 1'b1;
		if (int'(mirror_out_pos) >= fsize)
			mirror_out_pos = '0;
		mirror_pend = mirror_pend - 1'b1;
		return 1'b1;
	endfunction

	// one register write, mirrored after the edge that takes it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_ENABLED: mirror_en = data[0];
			CFG_WIDTH:   mirror_w = data[WIDTH_W-1:0];
			CFG_HEIGHT:  mirror_h = data[HEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	// drive one item until its transfer, then record what it should produce
	task automatic send_item(input pixel_item_t it, input bit typed, input bit typed_has,
			input pixel_result_t typed_res);
		logic [STORE_AW-1:0] src;
		bit copy_pix;
		bit emits;
		pixel_result_t res;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		// keep the neighbour away from store entries not yet written
		if (locate_source(it, src, copy_pix) && !copy_pix &&
				!(mirror_written[src] || (it.op == OP_PIXEL && src == mirror_wptr)))
			it.jit[5:0] = 6'o44;
		in_valid <= 1'b1;
		op <= it.op;
		pixel_in <= it.pix;
		jitter <= it.jit;
		frame_bypass <= it.byp;
		do
			@(posedge clk);
		while (!in_ready);
		emits = predict_scatter(it, res);
		if (typed) begin
			if (typed_has)
				expected_pixels.push_back(typed_res);
		end else if (emits) begin
			expected_pixels.push_back(res);
		end
	endtask

	// wait for every expected pixel, then let the pipeline settle
	task automatic settle_idle();
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// output check and receiver stalls
	always @(posedge clk) begin : out_check
		pixel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				if (mismatch_count < 40)
					$display("%0t: unexpected transfer, expected none, got pixel_out %h last %b",
						$time, pixel_out, last_of_frame);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (want.pix !== pixel_out || want.last !== last_of_frame) begin
					if (mismatch_count < 40)
						$display("%0t: mismatch, expected pixel_out %h last %b, got %h %b",
							$time, want.pix, want.last, pixel_out, last_of_frame);
					mismatch_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// stimulus
	initial begin
		pixel_item_t it;
		int budget, phase_no, n_items, i;
		bit big;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_PIXEL;
		pixel_in <= '0;
		jitter <= '0;
		frame_bypass <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ENABLED;
		cfg_data <= '0;

		// width 1, height 8: every row is a copy row, lag is six pixels
		dir_tab = '{
			'{OP_FLUSH, 32'h0000_0000, 9'd511, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'h0000_0000, 9'd0,   1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'hFFFF_FFFF, 9'd511, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'h8000_0000, 9'd256, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'h7FFF_FFFF, 9'd255, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'h0000_0001, 9'd36,  1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'hAAAA_AAAA, 9'd27,  1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'h5555_5555, 9'd63,  1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'hFFFF_FFFE, 9'd448, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
			'{OP_FLUSH, 32'h1234_5678, 9'd0,   1'b0, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd511, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
			'{OP_FLUSH, 32'hFFFF_FFFF, 9'd7,   1'b0, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd56,  1'b1, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd0,   1'b0, 1'b1, 1'b1, 32'h5555_5555, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd0,   1'b0, 1'b1, 1'b1, 32'hFFFF_FFFE, 1'b1},
			'{OP_FLUSH, 32'hDEAD_0000, 9'd511, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'h0F0F_0F0F, 9'd511, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'hF0F0_F0F0, 9'd0,   1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'h0000_FFFF, 9'd292, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_PIXEL, 32'hFFFF_0000, 9'd219, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd1,   1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd62,  1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd447, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
			'{OP_FLUSH, 32'h0000_0000, 9'd128, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: width 0 clamps to 1, height 0 raised to 8
		write_reg(CFG_WIDTH, 16'h0000);
		write_reg(CFG_HEIGHT, 16'h0000);
		write_reg(CFG_ENABLED, 16'h0001);
		write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_we <= 1'b0;
		for (i = 0; i < DIR_ROWS; i++) begin
			it.op = dir_tab[i].op;
			it.pix = dir_tab[i].pix;
			it.jit = dir_tab[i].jit;
			it.byp = dir_tab[i].byp;
			send_item(it, dir_tab[i].typed, dir_tab[i].has_res,
				'{dir_tab[i].res_pix, dir_tab[i].res_last});
		end
		in_valid <= 1'b0;
		settle_idle();

		// random phases; positions carry over, so geometry and enable change mid frame
		budget = 1950;
		phase_no = 0;
		while (budget > 0) begin
			case (phase_no % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 50; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 50; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			big = (phase_no % 9 == 5);
			if (big) begin
				// widest frame: a few pixels, all drained by flushes
				write_reg(CFG_WIDTH, (phase_no % 2 == 1) ? 16'd1024 : 16'hFFFF);
				write_reg(CFG_HEIGHT, 16'hFFFF);
			end else begin
				case ($urandom_range(0, 9))
					0: write_reg(CFG_WIDTH, 16'h0000);
					1: write_reg(CFG_WIDTH, 16'd1);
					2: write_reg(CFG_WIDTH, 16'd2);
					3: write_reg(CFG_WIDTH, 16'd3);
					4: write_reg(CFG_WIDTH, 16'hF803);
					default: write_reg(CFG_WIDTH, 16'($urandom_range(4, 12)));
				endcase
				case ($urandom_range(0, 7))
					0: write_reg(CFG_HEIGHT, 16'($urandom_range(0, 7)));
					1: write_reg(CFG_HEIGHT, 16'd8);
					2: write_reg(CFG_HEIGHT, 16'd9);
					3: write_reg(CFG_HEIGHT, 16'hFFFF);
					default: write_reg(CFG_HEIGHT, 16'($urandom_range(8, 16)));
				endcase
			end
			if ($urandom_range(0, 1) == 1)
				write_reg(CFG_ENABLED, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_UNUSED, 16'($urandom));
			cfg_we <= 1'b0;

			n_items = big ? 24 : $urandom_range(40, 110);
			for (i = 0; i < n_items; i++) begin
				it.op = (!big && $urandom_range(0, 9) == 0) ? OP_FLUSH : OP_PIXEL;
				it.pix = $urandom;
				it.jit = JIT_W'($urandom);
				it.byp = ($urandom_range(0, 3) == 0);
				send_item(it, 1'b0, 1'b0, '0);
			end
			budget -= n_items;

			// drain pending outputs in some phases, leave them in others
			if (big || $urandom_range(0, 1) == 1) begin
				while (mirror_pend != '0) begin
					it.op = OP_FLUSH;
					it.pix = $urandom;
					it.jit = JIT_W'($urandom);
					it.byp = $urandom_range(0, 1);
					send_item(it, 1'b0, 1'b0, '0);
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				it.op = OP_FLUSH;
				it.pix = $urandom;
				it.jit = JIT_W'($urandom);
				it.byp = $urandom_range(0, 1);
				send_item(it, 1'b0, 1'b0, '0);
			end
			in_valid <= 1'b0;
			settle_idle();
			phase_no++;
		end

		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

### filelist.f
sv/psj_pkg.sv
sv/psj_ram.sv
sv/psj_div.sv
sv/pixel_scatter_jitter_core.sv
sim/testbench.sv
